@@ hdl/rtc_bcd_pkg.sv @@
// Shared types, status codes and BCD helpers for the RTC date/time sanitize and decode block.
package rtc_bcd_pkg;

   // Status codes reported with each decoded word.
   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_READ_FAIL = 4'd1,
      ST_YEAR      = 4'd2,
      ST_MONTH     = 4'd3,
      ST_DAY       = 4'd4,
      ST_WEEKDAY   = 4'd5,
      ST_HOUR      = 4'd6,
      ST_MINUTE    = 4'd7,
      ST_SECOND    = 4'd8
   } status_type;

   // Range limits of the field checks, as BCD bytes, and the binary year base.
   localparam logic [7:0] YEAR_HI_MAX   = 8'h9F;
   localparam logic [7:0] MONTH_SPAN    = 8'h11;
   localparam logic [7:0] DAY_SPAN      = 8'h30;
   localparam logic [7:0] HOUR_MAX      = 8'h23;
   localparam logic [7:0] MIN_SEC_MAX   = 8'h5F;
   localparam logic [7:0] WEEKDAY_BAD   = 8'd7;
   localparam logic [7:0] DIGIT_MAX     = 8'd9;
   localparam logic [11:0] YEAR_BASE    = 12'd2000;

   // One raw reading as captured at the input.
   typedef struct packed {
      logic       read_ok;
      logic [7:0] year_bcd;
      logic [7:0] month_bcd;
      logic [7:0] day_bcd;
      logic [7:0] weekday_raw;
      logic [7:0] hour_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] second_bcd;
   } reading_type;

   // Two BCD digits to binary; nibbles above 9 are taken at face value.
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
   endfunction

   // Low digit is not a decimal digit.
   function automatic logic lo_bad(input logic [7:0] b);
      return {4'd0, b[3:0]} > DIGIT_MAX;
   endfunction

endpackage

@@ hdl/rtc_bcd_datetime_sanitize_decode_top.sv @@
// Top level of the RTC date/time sanitize and decode block.
//
// Takes one clock reading per cycle: a word is accepted on a rising edge with start high
// and busy low, and busy is always low, so a reading may be given every cycle. Its result
// appears with rsp_valid high for exactly one cycle, after passing through the input
// register and then through the check and decode logic into the result register.
// The receiver cannot stall, and no stall is needed since a result leaves every cycle.
module rtc_bcd_datetime_sanitize_decode_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_read_ok,
   input  logic [7:0]  req_year_bcd,
   input  logic [7:0]  req_month_bcd,
   input  logic [7:0]  req_day_bcd,
   input  logic [7:0]  req_weekday_raw,
   input  logic [7:0]  req_hour_bcd,
   input  logic [7:0]  req_minute_bcd,
   input  logic [7:0]  req_second_bcd,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [11:0] rsp_year_bin,
   output logic [7:0]  rsp_month_bin,
   output logic [7:0]  rsp_day_bin,
   output logic [7:0]  rsp_weekday_out,
   output logic [7:0]  rsp_hour_bin,
   output logic [7:0]  rsp_minute_bin,
   output logic [7:0]  rsp_second_bin
);

   rtc_bcd_pkg::reading_type rd_ff, rd_in;
   logic                     rd_valid_ff;

   logic                     year_bad, month_bad, day_bad, weekday_bad;
   logic                     hour_bad, minute_bad, second_bad;
   logic [7:0]               year_fix, month_fix, day_fix, weekday_fix;
   logic [7:0]               hour_fix, minute_fix, second_fix;
   rtc_bcd_pkg::status_type  status_in;

   logic                     out_valid_ff;
   logic [3:0]               status_ff;
   logic [11:0]              year_ff, year_in;
   logic [7:0]               month_ff, day_ff, weekday_ff, hour_ff, minute_ff, second_ff;

   // The block never holds off a word.
   assign busy = 1'b0;

   // Input register.
   always_comb begin
      rd_in.read_ok     = req_read_ok;
      rd_in.year_bcd    = req_year_bcd;
      rd_in.month_bcd   = req_month_bcd;
      rd_in.day_bcd     = req_day_bcd;
      rd_in.weekday_raw = req_weekday_raw;
      rd_in.hour_bcd    = req_hour_bcd;
      rd_in.minute_bcd  = req_minute_bcd;
      rd_in.second_bcd  = req_second_bcd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= start & ~busy;
      end
      if (start && !busy) begin
         rd_ff <= rd_in;
      end
   end

   // Field checks; they count only on a good read.
   always_comb begin
      year_bad    = rd_ff.read_ok &&
                    (({rd_ff.year_bcd[7:4], 4'd0} > rtc_bcd_pkg::YEAR_HI_MAX) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.year_bcd));
      month_bad   = rd_ff.read_ok &&
                    (((rd_ff.month_bcd - 8'd1) > rtc_bcd_pkg::MONTH_SPAN) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.month_bcd));
      day_bad     = rd_ff.read_ok &&
                    (((rd_ff.day_bcd - 8'd1) > rtc_bcd_pkg::DAY_SPAN) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.day_bcd));
      weekday_bad = rd_ff.read_ok && (rd_ff.weekday_raw == rtc_bcd_pkg::WEEKDAY_BAD);
      hour_bad    = rd_ff.read_ok &&
                    ((rd_ff.hour_bcd > rtc_bcd_pkg::HOUR_MAX) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.hour_bcd));
      minute_bad  = rd_ff.read_ok &&
                    ((rd_ff.minute_bcd > rtc_bcd_pkg::MIN_SEC_MAX) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.minute_bcd));
      second_bad  = rd_ff.read_ok &&
                    ((rd_ff.second_bcd > rtc_bcd_pkg::MIN_SEC_MAX) ||
                     rtc_bcd_pkg::lo_bad(rd_ff.second_bcd));
   end

   // Replace bad fields with safe values.
   always_comb begin
      year_fix    = year_bad    ? 8'h00 : rd_ff.year_bcd;
      month_fix   = month_bad   ? 8'h01 : rd_ff.month_bcd;
      day_fix     = day_bad     ? 8'h01 : rd_ff.day_bcd;
      weekday_fix = weekday_bad ? 8'h00 : rd_ff.weekday_raw;
      hour_fix    = hour_bad    ? 8'h00 : rd_ff.hour_bcd;
      minute_fix  = minute_bad  ? 8'h00 : rd_ff.minute_bcd;
      second_fix  = second_bad  ? 8'h00 : rd_ff.second_bcd;
   end

   // Status names the last failing check, so the later fields take priority.
   always_comb begin
      if (!rd_ff.read_ok) begin
         status_in = rtc_bcd_pkg::ST_READ_FAIL;
      end else if (second_bad) begin
         status_in = rtc_bcd_pkg::ST_SECOND;
      end else if (minute_bad) begin
         status_in = rtc_bcd_pkg::ST_MINUTE;
      end else if (hour_bad) begin
         status_in = rtc_bcd_pkg::ST_HOUR;
      end else if (weekday_bad) begin
         status_in = rtc_bcd_pkg::ST_WEEKDAY;
      end else if (day_bad) begin
         status_in = rtc_bcd_pkg::ST_DAY;
      end else if (month_bad) begin
         status_in = rtc_bcd_pkg::ST_MONTH;
      end else if (year_bad) begin
         status_in = rtc_bcd_pkg::ST_YEAR;
      end else begin
         status_in = rtc_bcd_pkg::ST_OK;
      end
   end

   assign year_in = {4'd0, rtc_bcd_pkg::bcd_to_bin(year_fix)} + rtc_bcd_pkg::YEAR_BASE;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= rd_valid_ff;
      end
      if (rd_valid_ff) begin
         status_ff  <= status_in;
         year_ff    <= year_in;
         month_ff   <= rtc_bcd_pkg::bcd_to_bin(month_fix);
         day_ff     <= rtc_bcd_pkg::bcd_to_bin(day_fix);
         weekday_ff <= weekday_fix;
         hour_ff    <= rtc_bcd_pkg::bcd_to_bin(hour_fix);
         minute_ff  <= rtc_bcd_pkg::bcd_to_bin(minute_fix);
         second_ff  <= rtc_bcd_pkg::bcd_to_bin(second_fix);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_year_bin    = year_ff;
   assign rsp_month_bin   = month_ff;
   assign rsp_day_bin     = day_ff;
   assign rsp_weekday_out = weekday_ff;
   assign rsp_hour_bin    = hour_ff;
   assign rsp_minute_bin  = minute_ff;
   assign rsp_second_bin  = second_ff;

endmodule

@@ hdl/rtc_bcd_checker.sv @@
// Port-level checker for the RTC date/time sanitize and decode block, with its bind.
module rtc_bcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_read_ok,
   input logic        rsp_valid,
   input logic [3:0]  rsp_status,
   input logic [11:0] rsp_year_bin,
   input logic [7:0]  rsp_month_bin,
   input logic [7:0]  rsp_hour_bin,
   input logic [7:0]  rsp_weekday_out
);

   // Every accepted word yields its result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   // No result without an earlier accepted word.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted word");

   // Read failure is reported exactly when the word carried a failed read.
   a_fail_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == rtc_bcd_pkg::ST_READ_FAIL) == $past(!req_read_ok, 2)))
      else $error("read failure status mismatch");

   // After a good read the year, month, hour and weekday are within their sanitized ranges.
   a_sanitized: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rtc_bcd_pkg::ST_READ_FAIL) |->
         (rsp_year_bin <= 12'd2099 && rsp_month_bin >= 8'd1 && rsp_month_bin <= 8'd12 &&
          rsp_hour_bin <= 8'd23 && rsp_weekday_out != 8'd7))
      else $error("sanitized field out of range");

endmodule

bind rtc_bcd_datetime_sanitize_decode_top rtc_bcd_checker u_rtc_bcd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_read_ok     (req_read_ok),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_year_bin    (rsp_year_bin),
   .rsp_month_bin   (rsp_month_bin),
   .rsp_hour_bin    (rsp_hour_bin),
   .rsp_weekday_out (rsp_weekday_out)
);
